>>> sv/bdd_pkg.sv
// bdd_pkg: shared types and constants for the decision-diagram node table evaluator
// used by bdd_node_mem and bdd_node_table_evaluator_core; no dependencies
`default_nettype none

package bdd_pkg;

   localparam int NODE_W = 8;
   localparam int VAR_W = 6;
   localparam int ASSIGN_W = 64;
   localparam int STATUS_W = 2;

   // opcodes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SET = 2'd1;
   localparam logic [1:0] OP_EVAL = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADIDX = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd3;

   // fixed node indices
   localparam logic [NODE_W-1:0] NODE_FALSE = 8'd0;
   localparam logic [NODE_W-1:0] NODE_TRUE = 8'd1;
   localparam logic [NODE_W-1:0] NODE_ROOT = 8'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [VAR_W-1:0] var_id;
      logic [NODE_W-1:0] parent_node;
      logic edge_value;
      logic [NODE_W-1:0] child_node;
      logic [ASSIGN_W-1:0] assignment;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_index;
      logic value;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // per-field write enables of the node memory
   typedef struct packed {
      logic var_en;
      logic false_en;
      logic true_en;
   } mem_we_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CHECK = 3'b010,
      S_READ = 3'b100
   } state_type;

endpackage

`default_nettype wire

>>> sv/bdd_node_mem.sv
// bdd_node_mem: node table storage, one write port and one registered read port
// holds each node's variable and its false and true successors; uses bdd_pkg
`default_nettype none

module bdd_node_mem #(
   parameter int DEPTH = 256,
   parameter int ADDR_W = 8
) (
   input wire logic clock,
   input wire bdd_pkg::mem_we_type we,
   input wire logic [ADDR_W-1:0] waddr,
   input wire logic [bdd_pkg::VAR_W-1:0] wvar,
   input wire logic [bdd_pkg::NODE_W-1:0] wsucc,
   input wire logic [ADDR_W-1:0] raddr,
   output logic [bdd_pkg::VAR_W-1:0] rvar,
   output logic [bdd_pkg::NODE_W-1:0] rfalse,
   output logic [bdd_pkg::NODE_W-1:0] rtrue
);

   logic [bdd_pkg::VAR_W-1:0] var_mem_ff [DEPTH];
   logic [bdd_pkg::NODE_W-1:0] false_mem_ff [DEPTH];
   logic [bdd_pkg::NODE_W-1:0] true_mem_ff [DEPTH];
   logic [bdd_pkg::VAR_W-1:0] rvar_ff;
   logic [bdd_pkg::NODE_W-1:0] rfalse_ff;
   logic [bdd_pkg::NODE_W-1:0] rtrue_ff;

   always_ff @(posedge clock) begin
      if (we.var_en) begin
         var_mem_ff[waddr] <= wvar;
      end
      if (we.false_en) begin
         false_mem_ff[waddr] <= wsucc;
      end
      if (we.true_en) begin
         true_mem_ff[waddr] <= wsucc;
      end
      rvar_ff <= var_mem_ff[raddr];
      rfalse_ff <= false_mem_ff[raddr];
      rtrue_ff <= true_mem_ff[raddr];
   end

   assign rvar = rvar_ff;
   assign rfalse = rfalse_ff;
   assign rtrue = rtrue_ff;

endmodule

`default_nettype wire

>>> sv/bdd_node_table_evaluator_core.sv
// bdd_node_table_evaluator_core: decision-diagram node table with add, set-edge and evaluate
// uses bdd_pkg and bdd_node_mem
//
//   channel | ports                         | handshake
//   --------+-------------------------------+----------------------------------
//   request | start, busy, req_data         | taken when start && !busy
//   result  | rsp_valid, rsp_data           | one-cycle strobe, cannot be held
//   csr     | csr_valid, csr_ready, csr_data| root variable, written on valid && ready
//
// add-node, set-edge and the unused opcode: the result word appears the cycle after
// accept and busy stays low.
// evaluate: the root is resolved in a check state alone, every other node in a check
// then a registered read, and a terminal in a final check; busy stays high throughout,
// with the walk capped at the node count; the word follows and is never stalled.
// reset is synchronous: node count 3, root successors both false, root variable 0.
`default_nettype none

module bdd_node_table_evaluator_core #(
   parameter int MAX_NODES = 256,
   parameter int NUM_VARS = 64
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire bdd_pkg::req_type req_data,
   output logic rsp_valid,
   output bdd_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [bdd_pkg::VAR_W-1:0] csr_data
);

   localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int CMP_W = (CNT_W > bdd_pkg::NODE_W) ? CNT_W : bdd_pkg::NODE_W;
   localparam logic [bdd_pkg::ASSIGN_W-1:0] VAR_MASK = (NUM_VARS >= bdd_pkg::ASSIGN_W) ?
      {bdd_pkg::ASSIGN_W{1'b1}} :
      ((bdd_pkg::ASSIGN_W'(1) << NUM_VARS) - bdd_pkg::ASSIGN_W'(1));

   bdd_pkg::state_type state_ff, state_in;
   logic [bdd_pkg::NODE_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] visits_ff, visits_in;
   logic [bdd_pkg::ASSIGN_W-1:0] assign_ff, assign_in;
   logic [CNT_W-1:0] node_count_ff, node_count_in;
   logic [bdd_pkg::VAR_W-1:0] root_var_ff, root_var_in;
   logic [bdd_pkg::NODE_W-1:0] root_false_ff, root_false_in;
   logic [bdd_pkg::NODE_W-1:0] root_true_ff, root_true_in;
   logic rsp_valid_ff, rsp_valid_in;
   bdd_pkg::rsp_type rsp_ff, rsp_in;

   bdd_pkg::mem_we_type mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [bdd_pkg::VAR_W-1:0] mem_wvar;
   logic [bdd_pkg::NODE_W-1:0] mem_wsucc;
   logic [ADDR_W-1:0] mem_raddr;
   logic [bdd_pkg::VAR_W-1:0] mem_rvar;
   logic [bdd_pkg::NODE_W-1:0] mem_rfalse;
   logic [bdd_pkg::NODE_W-1:0] mem_rtrue;

   logic [CMP_W-1:0] count_cmp;
   logic [CMP_W-1:0] cur_cmp;
   logic [CMP_W-1:0] parent_cmp;
   logic [CMP_W-1:0] child_cmp;

   bdd_node_mem #(
      .DEPTH(MAX_NODES),
      .ADDR_W(ADDR_W)
   ) u_mem (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wvar(mem_wvar),
      .wsucc(mem_wsucc),
      .raddr(mem_raddr),
      .rvar(mem_rvar),
      .rfalse(mem_rfalse),
      .rtrue(mem_rtrue)
   );

   assign count_cmp = CMP_W'(node_count_ff);
   assign cur_cmp = CMP_W'(cur_ff);
   assign parent_cmp = CMP_W'(req_data.parent_node);
   assign child_cmp = CMP_W'(req_data.child_node);

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      visits_in = visits_ff;
      assign_in = assign_ff;
      node_count_in = node_count_ff;
      root_var_in = root_var_ff;
      root_false_in = root_false_ff;
      root_true_in = root_true_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      mem_we = '0;
      mem_waddr = node_count_ff[ADDR_W-1:0];
      mem_wvar = req_data.var_id;
      mem_wsucc = bdd_pkg::NODE_FALSE;
      mem_raddr = ADDR_W'(cur_ff);

      if (csr_valid) begin
         root_var_in = csr_data;
      end

      unique case (state_ff)
         bdd_pkg::S_IDLE: begin
            if (start) begin
               rsp_in = '0;
               unique case (req_data.opcode)
                  bdd_pkg::OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (node_count_ff >= CNT_W'(MAX_NODES)) begin
                        rsp_in.status = bdd_pkg::STATUS_FULL;
                     end else begin
                        // new node starts with both successors at the false terminal
                        mem_we = '{var_en: 1'b1, false_en: 1'b1, true_en: 1'b1};
                        node_count_in = node_count_ff + CNT_W'(1);
                        rsp_in.node_index = bdd_pkg::NODE_W'(node_count_ff);
                     end
                  end
                  bdd_pkg::OP_SET: begin
                     rsp_valid_in = 1'b1;
                     if (req_data.parent_node < bdd_pkg::NODE_ROOT ||
                         parent_cmp >= count_cmp || child_cmp >= count_cmp) begin
                        rsp_in.status = bdd_pkg::STATUS_BADIDX;
                     end else if (req_data.parent_node == bdd_pkg::NODE_ROOT) begin
                        // root successors live in flops so they reset to false
                        if (req_data.edge_value) begin
                           root_true_in = req_data.child_node;
                        end else begin
                           root_false_in = req_data.child_node;
                        end
                     end else begin
                        mem_waddr = ADDR_W'(req_data.parent_node);
                        mem_wsucc = req_data.child_node;
                        mem_we.true_en = req_data.edge_value;
                        mem_we.false_en = ~req_data.edge_value;
                     end
                  end
                  bdd_pkg::OP_EVAL: begin
                     cur_in = bdd_pkg::NODE_ROOT;
                     visits_in = '0;
                     assign_in = req_data.assignment & VAR_MASK;
                     state_in = bdd_pkg::S_CHECK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         bdd_pkg::S_CHECK: begin
            priority if (cur_ff < bdd_pkg::NODE_ROOT) begin
               rsp_valid_in = 1'b1;
               rsp_in.value = cur_ff[0];
               rsp_in.status = bdd_pkg::STATUS_OK;
               state_in = bdd_pkg::S_IDLE;
            end else if (visits_ff >= node_count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = bdd_pkg::STATUS_LIMIT;
               state_in = bdd_pkg::S_IDLE;
            end else if (cur_cmp >= count_cmp) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = bdd_pkg::STATUS_BADIDX;
               state_in = bdd_pkg::S_IDLE;
            end else if (cur_ff == bdd_pkg::NODE_ROOT) begin
               visits_in = visits_ff + CNT_W'(1);
               cur_in = assign_ff[root_var_ff] ? root_true_ff : root_false_ff;
            end else begin
               // node read issued at cur this cycle, data back next cycle
               state_in = bdd_pkg::S_READ;
            end
         end
         bdd_pkg::S_READ: begin
            visits_in = visits_ff + CNT_W'(1);
            cur_in = assign_ff[mem_rvar] ? mem_rtrue : mem_rfalse;
            state_in = bdd_pkg::S_CHECK;
         end
         default: begin
            state_in = bdd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdd_pkg::S_IDLE;
         node_count_ff <= CNT_W'(3);
         root_var_ff <= '0;
         root_false_ff <= bdd_pkg::NODE_FALSE;
         root_true_ff <= bdd_pkg::NODE_FALSE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         node_count_ff <= node_count_in;
         root_var_ff <= root_var_in;
         root_false_ff <= root_false_in;
         root_true_ff <= root_true_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      visits_ff <= visits_in;
      assign_ff <= assign_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != bdd_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire
